// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RRTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define RRTS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int TASK_ID_W = 4;
    localparam int SLEEP_MS_W = 31;
    localparam int TICK_MS_W = 10;
    localparam int NUM_IDS = 1 << TASK_ID_W;

    typedef logic [1:0]            cmd_t;
    typedef logic [TASK_ID_W-1:0]  task_id_t;
    typedef logic [SLEEP_MS_W-1:0] sleep_ms_t;
    typedef logic [TICK_MS_W-1:0]  tick_ms_t;

    localparam cmd_t CMD_TICK  = 2'd0;
    localparam cmd_t CMD_SPAWN = 2'd1;
    localparam cmd_t CMD_YIELD = 2'd2;
    localparam cmd_t CMD_SLEEP = 2'd3;

    localparam tick_ms_t MS_PER_TICK_RESET = 10'd10;

    // Verdict of the timer unit for one sleeper
    typedef struct packed {
        logic      wake;
        sleep_ms_t left;
    } tick_res_t;

endpackage

// File: design/rrts_if.sv
// ----------------------------------------------------------------------------
// rrts_if
// Valid/ready channels of the scheduler: commands, results, configuration.
// ----------------------------------------------------------------------------
interface rrts_cmd_if;
    import rrts_pkg::*;
    logic      valid;
    logic      ready;
    cmd_t      cmd;
    task_id_t  task_id;
    sleep_ms_t sleep_ms;
    modport source (output valid, cmd, task_id, sleep_ms, input ready);
    modport sink (input valid, cmd, task_id, sleep_ms, output ready);
endinterface

interface rrts_res_if;
    import rrts_pkg::*;
    logic     valid;
    logic     ready;
    task_id_t running_task;
    logic     idle;
    modport source (output valid, running_task, idle, input ready);
    modport sink (input valid, running_task, idle, output ready);
endinterface

interface rrts_cfg_if;
    import rrts_pkg::*;
    logic     valid;
    logic     ready;
    tick_ms_t ms_per_tick;
    modport source (output valid, ms_per_tick, input ready);
    modport sink (input valid, ms_per_tick, output ready);
endinterface

// File: design/round_robin_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top
// Round-robin task scheduler with a ready queue, a sleep list and sleep timers.
// ----------------------------------------------------------------------------
// Usage:
//   sched_cmd carries one command item: tick, spawn (task_id), yield or sleep
//   (sleep_ms). Every command gives exactly one result item on sched_res:
//   the running task after the command and the idle flag.
//   cfg writes ms_per_tick and is always ready; the user must write it between items (unchecked).
// Steps: spawn and sleep while idle go straight to done; yield and tick
//   rotate the ready queue, then done; sleep first scans the ready queue
//   (if its task is on it) and tick first walks the sleep list (if any).
//   The result turns valid in the same cycle that the scheduler is ready again.
//   The ready queue and sleep list sit in RAMs with one read and one write
//   port; sleep walks the ready queue and tick walks the sleep list, one
//   entry a cycle, tick through the timer unit.
// Reset: both lists empty, idle task running, ms_per_tick = 10.
//   No clearing pass; the lists are tracked by counts and presence bits.
// Stall: a result waits in the output register while the next command runs;
//   the scheduler holds in its done state only when its next result is due
//   before the waiting one is taken, and takes no new command meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_task_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input logic        clk,
    input logic        rst_n,
    rrts_cmd_if.sink   sched_cmd,
    rrts_res_if.source sched_res,
    rrts_cfg_if.sink   cfg
);
    import rrts_pkg::*;

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = AW + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RS_READ = 3'd1;
    localparam logic [2:0] ST_RS_ROT  = 3'd2;
    localparam logic [2:0] ST_SL_SCAN = 3'd3;
    localparam logic [2:0] ST_TK_WALK = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // Ready queue is circular from rd_head; sleep list is packed from 0.
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(MAX_TASKS))
        begin
            s = s - SW'(MAX_TASKS);
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      rd_head_reg, rd_head_next;
    logic [CW-1:0]      rd_count_reg, rd_count_next;
    logic [CW-1:0]      sl_count_reg, sl_count_next;
    logic [NUM_IDS-1:0] rdy_flags_reg, rdy_flags_next;
    logic [NUM_IDS-1:0] slp_flags_reg, slp_flags_next;
    task_id_t           run_id_reg, run_id_next;
    logic               run_idle_reg, run_idle_next;
    tick_ms_t           mpt_reg, mpt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic               found_reg, found_next;
    logic               res_valid_reg, res_valid_next;
    task_id_t           res_task_reg;
    logic               res_idle_reg;
    logic               res_load;

    sleep_ms_t          rem_reg [NUM_IDS];
    logic               rem_we;
    task_id_t           rem_waddr;
    sleep_ms_t          rem_wdata;

    logic               rq_we;
    logic [AW-1:0]      rq_waddr, rq_raddr;
    task_id_t           rq_wdata, rq_rdata;
    logic               sq_we;
    logic [AW-1:0]      sq_waddr, sq_raddr;
    task_id_t           sq_wdata, sq_rdata;

    logic [AW-1:0]      rq_tail;
    logic               rq_room;
    logic               sq_room;
    logic               cmd_acc;
    logic               id_ok;
    logic               hit;
    tick_res_t          alu_res;

    rrts_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_ready_ram (
        .clk   (clk),
        .we    (rq_we),
        .waddr (rq_waddr),
        .wdata (rq_wdata),
        .raddr (rq_raddr),
        .rdata (rq_rdata)
    );

    rrts_ram #(.WIDTH(TASK_ID_W), .DEPTH(MAX_TASKS)) u_sleep_ram (
        .clk   (clk),
        .we    (sq_we),
        .waddr (sq_waddr),
        .wdata (sq_wdata),
        .raddr (sq_raddr),
        .rdata (sq_rdata)
    );

    // Timer unit sees the sleeper whose id the sleep RAM returns
    rrts_tick_alu u_alu (
        .remaining (rem_reg[sq_rdata]),
        .step      (mpt_reg),
        .res       (alu_res)
    );

    assign rq_tail = wrap_add(rd_head_reg, rd_count_reg);
    assign rq_room = (rd_count_reg != CW'(MAX_TASKS));
    assign sq_room = (sl_count_reg != CW'(MAX_TASKS));
    assign cmd_acc = sched_cmd.valid && (state_reg == ST_IDLE);
    assign id_ok   = (32'(sched_cmd.task_id) < MAX_TASKS);
    assign hit     = (rq_rdata == run_id_reg);

    assign sched_cmd.ready     = (state_reg == ST_IDLE);
    assign sched_res.valid     = res_valid_reg;
    assign sched_res.running_task = res_task_reg;
    assign sched_res.idle      = res_idle_reg;
    assign cfg.ready           = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        rd_head_next   = rd_head_reg;
        rd_count_next  = rd_count_reg;
        sl_count_next  = sl_count_reg;
        rdy_flags_next = rdy_flags_reg;
        slp_flags_next = slp_flags_reg;
        run_id_next    = run_id_reg;
        run_idle_next  = run_idle_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        found_next     = found_reg;
        mpt_next       = cfg.valid ? cfg.ms_per_tick : mpt_reg;
        res_load       = 1'b0;

        rq_we     = 1'b0;
        rq_waddr  = rq_tail;
        rq_wdata  = sched_cmd.task_id;
        rq_raddr  = rd_head_reg;
        sq_we     = 1'b0;
        sq_waddr  = sl_count_reg[AW-1:0];
        sq_wdata  = run_id_reg;
        sq_raddr  = '0;
        rem_we    = 1'b0;
        rem_waddr = run_id_reg;
        rem_wdata = sched_cmd.sleep_ms;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (sched_cmd.cmd)
                        CMD_TICK:
                        begin
                            // sleep RAM already reads entry 0, ready RAM the head
                            if (sl_count_reg == '0)
                            begin
                                state_next = ST_RS_ROT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                kept_next  = '0;
                                state_next = ST_TK_WALK;
                            end
                        end
                        CMD_SPAWN:
                        begin
                            if (id_ok && !rdy_flags_reg[sched_cmd.task_id]
                                && !slp_flags_reg[sched_cmd.task_id] && rq_room)
                            begin
                                rq_we = 1'b1;
                                rd_count_next = rd_count_reg + CW'(1);
                                rdy_flags_next[sched_cmd.task_id] = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        CMD_YIELD:
                        begin
                            state_next = ST_RS_ROT;
                        end
                        CMD_SLEEP:
                        begin
                            if (run_idle_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                rem_we = 1'b1;
                                if (!slp_flags_reg[run_id_reg] && sq_room)
                                begin
                                    sq_we = 1'b1;
                                    sl_count_next = sl_count_reg + CW'(1);
                                    slp_flags_next[run_id_reg] = 1'b1;
                                end
                                rdy_flags_next[run_id_reg] = 1'b0;
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = rdy_flags_reg[run_id_reg] ? ST_SL_SCAN
                                                                       : ST_RS_READ;
                            end
                        end
                    endcase
                end
            end
            ST_SL_SCAN:
            begin
                // rq_rdata is queue entry idx; entries after the match move up one
                rq_raddr = wrap_add(rd_head_reg, CW'(idx_reg) + CW'(1));
                if (found_reg)
                begin
                    rq_we    = 1'b1;
                    rq_waddr = wrap_add(rd_head_reg, CW'(idx_reg - 1'b1));
                    rq_wdata = rq_rdata;
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                end
                if (CW'(idx_reg) + CW'(1) == rd_count_reg)
                begin
                    if (found_reg || hit)
                    begin
                        rd_count_next = rd_count_reg - CW'(1);
                    end
                    state_next = ST_RS_READ;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TK_WALK:
            begin
                // sq_rdata is sleeper idx; survivors are packed down to kept
                sq_raddr = idx_reg + 1'b1;
                if (alu_res.wake)
                begin
                    if (rq_room)
                    begin
                        rq_we    = 1'b1;
                        rq_wdata = sq_rdata;
                        rd_count_next = rd_count_reg + CW'(1);
                        rdy_flags_next[sq_rdata] = 1'b1;
                    end
                    slp_flags_next[sq_rdata] = 1'b0;
                end
                else
                begin
                    rem_we    = 1'b1;
                    rem_waddr = sq_rdata;
                    rem_wdata = alu_res.left;
                    sq_we     = 1'b1;
                    sq_waddr  = kept_reg[AW-1:0];
                    sq_wdata  = sq_rdata;
                    kept_next = kept_reg + CW'(1);
                end
                if (CW'(idx_reg) + CW'(1) == sl_count_reg)
                begin
                    sl_count_next = kept_next;
                    state_next    = ST_RS_READ;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RS_READ:
            begin
                state_next = ST_RS_ROT;
            end
            ST_RS_ROT:
            begin
                // rq_rdata is the queue head: run it and rotate it to the tail
                if (rd_count_reg == '0)
                begin
                    run_idle_next = 1'b1;
                    run_id_next   = '0;
                end
                else
                begin
                    rq_we         = 1'b1;
                    rq_wdata      = rq_rdata;
                    rd_head_next  = wrap_add(rd_head_reg, CW'(1));
                    run_id_next   = rq_rdata;
                    run_idle_next = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || sched_res.ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_valid_next = res_load || (res_valid_reg && !sched_res.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_head_reg   <= '0;
            rd_count_reg  <= '0;
            sl_count_reg  <= '0;
            rdy_flags_reg <= '0;
            slp_flags_reg <= '0;
            run_id_reg    <= '0;
            run_idle_reg  <= 1'b1;
            mpt_reg       <= MS_PER_TICK_RESET;
            idx_reg       <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_head_reg   <= rd_head_next;
            rd_count_reg  <= rd_count_next;
            sl_count_reg  <= sl_count_next;
            rdy_flags_reg <= rdy_flags_next;
            slp_flags_reg <= slp_flags_next;
            run_id_reg    <= run_id_next;
            run_idle_reg  <= run_idle_next;
            mpt_reg       <= mpt_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload: timers and result fields
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_reg[rem_waddr] <= rem_wdata;
        end
        if (res_load)
        begin
            res_task_reg <= run_id_reg;
            res_idle_reg <= run_idle_reg;
        end
    end

    `RRTS_NEVER(a_lists_disjoint, (rdy_flags_reg & slp_flags_reg) != '0, "task on both lists")
    `RRTS_ASSERT(a_ready_count, (state_reg == ST_IDLE) |->
        ($countones(rdy_flags_reg) == int'(rd_count_reg)), "ready count mismatch")
    `RRTS_ASSERT(a_sleep_count, (state_reg == ST_IDLE) |->
        ($countones(slp_flags_reg) == int'(sl_count_reg)), "sleep count mismatch")
    `RRTS_ASSERT(a_total, (state_reg == ST_IDLE) |->
        ((SW + 1)'(rd_count_reg) + (SW + 1)'(sl_count_reg) <= (SW + 1)'(MAX_TASKS)),
        "lists overflow")
    `RRTS_ASSERT(a_idle_id, run_idle_reg |-> (run_id_reg == '0), "idle with nonzero task id")

endmodule

// File: design/rrts_ram.sv
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rrts_tick_alu.sv
// ----------------------------------------------------------------------------
// rrts_tick_alu
// Timer unit: one subtract decides whether a sleeper wakes on this tick.
// ----------------------------------------------------------------------------
module rrts_tick_alu (
    input  rrts_pkg::sleep_ms_t remaining,
    input  rrts_pkg::tick_ms_t  step,
    output rrts_pkg::tick_res_t res
);
    import rrts_pkg::*;

    logic [SLEEP_MS_W:0] diff;

    // Borrow out or zero difference means remaining <= step
    assign diff = {1'b0, remaining} - {1'b0, SLEEP_MS_W'(step)};
    assign res.wake = diff[SLEEP_MS_W] || (diff[SLEEP_MS_W-1:0] == '0);
    assign res.left = diff[SLEEP_MS_W-1:0];

endmodule

// File: verif/rrts_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_schedule_checker
// Watches the scheduler channels, keeps a shadow of the ready queue, the
// sleep list and the timers, and compares every result item with the
// running task that the shadow predicts.
// ----------------------------------------------------------------------------
module rrts_schedule_checker (
    input  logic clk,
    input  logic rst_n,
    rrts_cmd_if  cmd_ch,
    rrts_res_if  res_ch,
    rrts_cfg_if  cfg_ch,
    output int   fail_count,
    output int   pending
);
    import rrts_pkg::*;

    typedef struct packed {
        task_id_t running_task;
        logic     idle;
    } run_state_t;

    // Shadow state of the scheduler
    task_id_t    ready_q  [NUM_IDS];
    logic [4:0]  ready_n;
    task_id_t    sleep_q  [NUM_IDS];
    logic [4:0]  sleep_n;
    logic [31:0] ms_left  [NUM_IDS];
    task_id_t    run_id;
    logic        run_idle;
    tick_ms_t    tick_ms;

    run_state_t  expected_runs[$];
    int          mismatches;

    function automatic logic [4:0] ready_pos(task_id_t id);
        for (int i = 0; i < int'(ready_n); i++)
            if (ready_q[i] == id)
                return 5'(i);
        return ready_n;
    endfunction

    function automatic logic [4:0] sleep_pos(task_id_t id);
        for (int i = 0; i < int'(sleep_n); i++)
            if (sleep_q[i] == id)
                return 5'(i);
        return sleep_n;
    endfunction

    function automatic void push_ready(task_id_t id);
        if (ready_n < NUM_IDS)
        begin
            ready_q[ready_n[3:0]] = id;
            ready_n = ready_n + 5'd1;
        end
    endfunction

    function automatic void drop_ready(logic [4:0] pos);
        if (pos < ready_n)
        begin
            for (int i = int'(pos); i + 1 < int'(ready_n); i++)
                ready_q[i] = ready_q[i + 1];
            ready_n = ready_n - 5'd1;
        end
    endfunction

    // Head of the ready queue runs and goes to the tail
    function automatic void rotate_ready();
        task_id_t head;
        if (ready_n == 0)
        begin
            run_idle = 1'b1;
            run_id   = '0;
        end
        else
        begin
            head = ready_q[0];
            drop_ready(5'd0);
            push_ready(head);
            run_id   = head;
            run_idle = 1'b0;
        end
    endfunction

    // Compaction in place is safe: the kept index never passes the read index
    function automatic void age_sleepers();
        int       kept;
        task_id_t id;
        kept = 0;
        for (int i = 0; i < int'(sleep_n); i++)
        begin
            id = sleep_q[i];
            if (ms_left[id] <= {22'd0, tick_ms})
                push_ready(id);
            else
            begin
                ms_left[id]   = ms_left[id] - {22'd0, tick_ms};
                sleep_q[kept] = id;
                kept++;
            end
        end
        sleep_n = 5'(kept);
        rotate_ready();
    endfunction

    function automatic void admit_task(task_id_t id);
        if (ready_pos(id) == ready_n && sleep_pos(id) == sleep_n)
            push_ready(id);
    endfunction

    function automatic void put_to_sleep(sleep_ms_t ms);
        if (!run_idle)
        begin
            drop_ready(ready_pos(run_id));
            ms_left[run_id] = {1'b0, ms};
            if (sleep_pos(run_id) == sleep_n && sleep_n < NUM_IDS)
            begin
                sleep_q[sleep_n[3:0]] = run_id;
                sleep_n = sleep_n + 5'd1;
            end
            rotate_ready();
        end
    endfunction

    function automatic run_state_t next_run(cmd_t c, task_id_t id, sleep_ms_t ms);
        run_state_t r;
        case (c)
            CMD_TICK:  age_sleepers();
            CMD_SPAWN: admit_task(id);
            CMD_YIELD: rotate_ready();
            default:   put_to_sleep(ms);
        endcase
        r.running_task = run_idle ? '0 : run_id;
        r.idle         = run_idle;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        run_state_t exp_run;
        if (!rst_n)
        begin
            ready_n    = '0;
            sleep_n    = '0;
            run_id     = '0;
            run_idle   = 1'b1;
            tick_ms    = MS_PER_TICK_RESET;
            mismatches = 0;
            expected_runs.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: unexpected result item running_task %0d idle %0b",
                             $time, res_ch.running_task, res_ch.idle);
                    mismatches++;
                end
                else
                begin
                    exp_run = expected_runs.pop_front();
                    if (res_ch.running_task !== exp_run.running_task)
                    begin
                        $display("%0t: running_task expected %0d, actual %0d",
                                 $time, exp_run.running_task, res_ch.running_task);
                        mismatches++;
                    end
                    if (res_ch.idle !== exp_run.idle)
                    begin
                        $display("%0t: idle expected %0b, actual %0b",
                                 $time, exp_run.idle, res_ch.idle);
                        mismatches++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                tick_ms = cfg_ch.ms_per_tick;
            if (cmd_ch.valid && cmd_ch.ready)
                expected_runs.push_back(next_run(cmd_ch.cmd, cmd_ch.task_id,
                                                 cmd_ch.sleep_ms));
            fail_count <= mismatches;
            pending    <= expected_runs.size();
        end
    end

endmodule

// File: verif/tb_round_robin_task_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_task_scheduler_top
// Stimulus and verdict for the round-robin task scheduler: a directed run
// over the corner cases, then random command streams under six tick
// settings and three idling patterns, checked item by item by the checker.
// ----------------------------------------------------------------------------
module tb_round_robin_task_scheduler_top;
    import rrts_pkg::*;

    logic clk;
    logic rst_n;

    // Percentages of cycles in which sender / receiver hold off
    int snd_idle_pct;
    int rcv_idle_pct;

    int fail_count;
    int pending;

    rrts_cmd_if cmd_ch ();
    rrts_res_if res_ch ();
    rrts_cfg_if cfg_ch ();

    round_robin_task_scheduler_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched_cmd (cmd_ch),
        .sched_res (res_ch),
        .cfg       (cfg_ch)
    );

    rrts_schedule_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .res_ch     (res_ch),
        .cfg_ch     (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // Hard stop; far beyond the slowest legal run (~1.5k items)
    initial
    begin
        #5_000_000;
        $display("round_robin_task_scheduler_top verification failed");
        $finish;
    end

    // One command item; valid stays up across back-to-back items, so only
    // a hold-off gap or a drain lowers it.
    task automatic issue(cmd_t c, task_id_t id, sleep_ms_t ms);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= c;
        cmd_ch.task_id  <= id;
        cmd_ch.sleep_ms <= ms;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Let every outstanding result come back, then a few cycles more so the
    // scheduler is back in its idle state before the register changes.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tick_ms(tick_ms_t v);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.ms_per_tick <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random command with a bias towards well-formed traffic: sleeps are
    // mostly short against the tick so that sleepers keep waking up. A
    // full-range sleep parks a task for good, so they are rationed.
    task automatic random_item(tick_ms_t mpt, ref int long_sleeps_left);
        int        sel;
        task_id_t  id;
        sleep_ms_t ms;
        sel = $urandom_range(0, 99);
        id  = task_id_t'($urandom);
        ms  = sleep_ms_t'($urandom);
        if (sel < 30)
            issue(CMD_SPAWN, id, ms);
        else if (sel < 50)
            issue(CMD_YIELD, id, ms);
        else if (sel < 75)
        begin
            if (long_sleeps_left > 0 && $urandom_range(0, 99) == 0)
                long_sleeps_left--;
            else if (mpt == 0)
                ms = ($urandom_range(0, 1) == 0) ? '0 : sleep_ms_t'($urandom_range(1, 3));
            else
                ms = sleep_ms_t'($urandom_range(0, 4 * int'(mpt) + 2));
            issue(CMD_SLEEP, id, ms);
        end
        else
            issue(CMD_TICK, id, ms);
    endtask

    initial
    begin
        tick_ms_t mpt;
        int       long_sleeps_left;

        // Known values on every input before the first edge
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.cmd         <= CMD_TICK;
        cmd_ch.task_id     <= '0;
        cmd_ch.sleep_ms    <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.ms_per_tick <= MS_PER_TICK_RESET;
        snd_idle_pct = 27;
        rcv_idle_pct = 67;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset tick of 10 ms
        issue(CMD_YIELD, 4'd3, '0);             // reschedule with nothing ready
        issue(CMD_SLEEP, 4'd0, 31'd5);          // sleep while idle: ignored
        issue(CMD_TICK,  4'd0, '0);             // tick with an empty sleep list
        issue(CMD_SPAWN, 4'd0, '0);
        issue(CMD_SPAWN, 4'd15, '0);
        issue(CMD_SPAWN, 4'd0, '0);             // already on the ready queue
        issue(CMD_YIELD, 4'd0, '0);
        issue(CMD_SLEEP, 4'd0, 31'd0);          // zero sleep wakes on next tick
        issue(CMD_SPAWN, 4'd0, '0);             // already on the sleep list
        issue(CMD_TICK,  4'd0, '0);
        issue(CMD_SPAWN, 4'd5, '0);
        issue(CMD_YIELD, 4'd0, '0);
        issue(CMD_SLEEP, 4'd0, 31'd10);         // exactly one tick: wakes on the first tick
        issue(CMD_YIELD, 4'd0, '0);
        issue(CMD_SLEEP, 4'd0, 31'd11);         // one over: needs two ticks
        issue(CMD_TICK,  4'd0, '0);
        issue(CMD_TICK,  4'd0, '0);
        issue(CMD_SLEEP, 4'd0, 31'h7FFF_FFFF);  // longest sleep, does not wake in this run
        issue(CMD_SPAWN, 4'd9, '0);
        issue(CMD_SPAWN, 4'd10, '0);
        issue(CMD_TICK,  4'd0, '0);
        issue(CMD_YIELD, 4'd0, '0);
        issue(CMD_SLEEP, 4'd0, 31'd1);
        issue(CMD_TICK,  4'd0, '0);
        issue(CMD_YIELD, 4'd0, '0);
        drain();

        // Random part: six segments, each with its own tick setting.
        // Segments 0-1 sender-light, 2-3 receiver-light, 4-5 no idling.
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:       mpt = 10'd1;
                1:       mpt = 10'd1000;
                2:       mpt = 10'd0;
                3:       mpt = 10'd1023;
                default: mpt = tick_ms_t'($urandom_range(2, 999));
            endcase
            case (seg)
                0, 1:
                begin
                    snd_idle_pct = 27;
                    rcv_idle_pct = 67;
                end
                2, 3:
                begin
                    snd_idle_pct = 67;
                    rcv_idle_pct = 27;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            write_tick_ms(mpt);
            long_sleeps_left = 1;
            for (int n = 0; n < 240; n++)
                random_item(mpt, long_sleeps_left);
            drain();
        end

        // Any stray result would show up in this window
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("round_robin_task_scheduler_top verification clean");
        else
            $display("round_robin_task_scheduler_top verification failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/rrts_pkg.sv
design/rrts_if.sv
design/rrts_ram.sv
design/rrts_tick_alu.sv
design/round_robin_task_scheduler_top.sv
verif/rrts_schedule_checker.sv
verif/tb_round_robin_task_scheduler_top.sv
